### hw/rtl/afc_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// afc_pkg
// Shared types, field layout and sizing constants for the frustum cull block.
// -----------------------------------------------------------------------------
package afc_pkg;

	localparam int COORD_BITS = 32;
	localparam int FIELD_W    = 32;
	localparam int COORD_W    = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
	localparam int PROD_W     = 2 * COORD_W;
	localparam int D_SHIFT    = 16;
	localparam int D_TERM_W   = COORD_W + D_SHIFT;
	localparam int TERM_W     = (PROD_W > D_TERM_W) ? PROD_W : D_TERM_W;
	localparam int SUM_W      = TERM_W + 2;

	localparam int NUM_PLANES = 6;
	localparam int PIDX_W     = 3;
	localparam int FAR_PLANE  = 1;
	localparam int AXES       = 3;

	localparam int IN_BITS    = PIDX_W + 10 * FIELD_W;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 8;

	localparam int OFS_A     = PIDX_W;
	localparam int OFS_B     = OFS_A + FIELD_W;
	localparam int OFS_C     = OFS_B + FIELD_W;
	localparam int OFS_D     = OFS_C + FIELD_W;
	localparam int OFS_MIN_X = OFS_D + FIELD_W;
	localparam int OFS_MIN_Y = OFS_MIN_X + FIELD_W;
	localparam int OFS_MIN_Z = OFS_MIN_Y + FIELD_W;
	localparam int OFS_MAX_X = OFS_MIN_Z + FIELD_W;
	localparam int OFS_MAX_Y = OFS_MAX_X + FIELD_W;
	localparam int OFS_MAX_Z = OFS_MAX_Y + FIELD_W;

	typedef enum logic {
		MODE_LOAD = 1'b0,
		MODE_TEST = 1'b1
	} mode_t;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t a;
		coord_t b;
		coord_t c;
		coord_t d;
	} plane_t;

	typedef struct packed {
		coord_t lo_x;
		coord_t lo_y;
		coord_t lo_z;
		coord_t hi_x;
		coord_t hi_y;
		coord_t hi_z;
	} box_t;

	// Low COORD_W bits of a field, read as a signed coordinate.
	function automatic coord_t field_coord(input logic [FIELD_W-1:0] f);
		return coord_t'(f[COORD_W-1:0]);
	endfunction

endpackage

### hw/rtl/afc_plane_eval.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// afc_plane_eval
// Evaluates one plane equation at the box corner picked by the corner bits.
// -----------------------------------------------------------------------------
module afc_plane_eval
	import afc_pkg::*;
(
	input  logic                clk,
	input  logic                en,
	input  plane_t              plane,
	input  logic [AXES-1:0]     sel,
	input  box_t                box,
	output logic                outside
);

	coord_t x, y, z;
	logic signed [D_TERM_W-1:0] d_term;
	logic signed [PROD_W-1:0] prod_x_s2, prod_y_s2, prod_z_s2;
	logic signed [D_TERM_W-1:0] d_term_s2;
	logic signed [SUM_W-1:0] sum;

	assign x      = sel[0] ? box.hi_x : box.lo_x;
	assign y      = sel[1] ? box.hi_y : box.lo_y;
	assign z      = sel[2] ? box.hi_z : box.lo_z;
	assign d_term = {plane.d, {D_SHIFT{1'b0}}};

	always_ff @(posedge clk) begin
		if (en) begin
			prod_x_s2 <= plane.a * x;
			prod_y_s2 <= plane.b * y;
			prod_z_s2 <= plane.c * z;
			d_term_s2 <= d_term;
		end
	end

	assign sum = SUM_W'(prod_x_s2) + SUM_W'(prod_y_s2) + SUM_W'(prod_z_s2)
		+ SUM_W'(d_term_s2);
	assign outside = sum[SUM_W-1];

endmodule

### hw/rtl/aabb_frustum_cull.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// aabb_frustum_cull
// Tests an axis-aligned box against six stored frustum planes (p-vertex method).
// -----------------------------------------------------------------------------
// Throughput: one word per cycle when the output is not stalled; input register,
// product register (one 32x32 multiplier per axis per plane) and result register
// form the pipeline. A stalled output holds the whole pipeline, so tready follows
// the output side. Reset clears the pipeline valid bits and the far plane enable;
// the plane store is not reset and each plane must be loaded before a box is
// tested.
module aabb_frustum_cull
	import afc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic                    cfg_wdata,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	// plane_index, coef_a, coef_b, coef_c, coef_d, min_x, min_y, min_z,
	// max_x, max_y, max_z, zero fill.
	input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
	// mode.
	input  logic [0:0]              s_axis_tuser,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// culled, zero fill.
	output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
	// is_test.
	output logic [0:0]              m_axis_tuser
);

	logic far_en_q;
	logic adv, accept, is_load;
	logic [PIDX_W-1:0] pidx;
	plane_t in_plane;
	box_t in_box;

	plane_t plane_q [NUM_PLANES];
	logic [AXES-1:0] sel_q [NUM_PLANES];

	logic valid_s1, is_test_s1;
	box_t box_s1;
	logic valid_s2, is_test_s2;
	logic [NUM_PLANES-1:0] outside, plane_en;
	logic out_valid_q, culled_q, is_test_q;

	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid && adv;
	assign is_load       = (mode_t'(s_axis_tuser[0]) == MODE_LOAD);
	assign pidx          = s_axis_tdata[PIDX_W-1:0];

	assign in_plane.a = field_coord(s_axis_tdata[OFS_A +: FIELD_W]);
	assign in_plane.b = field_coord(s_axis_tdata[OFS_B +: FIELD_W]);
	assign in_plane.c = field_coord(s_axis_tdata[OFS_C +: FIELD_W]);
	assign in_plane.d = field_coord(s_axis_tdata[OFS_D +: FIELD_W]);
	assign in_box.lo_x = field_coord(s_axis_tdata[OFS_MIN_X +: FIELD_W]);
	assign in_box.lo_y = field_coord(s_axis_tdata[OFS_MIN_Y +: FIELD_W]);
	assign in_box.lo_z = field_coord(s_axis_tdata[OFS_MIN_Z +: FIELD_W]);
	assign in_box.hi_x = field_coord(s_axis_tdata[OFS_MAX_X +: FIELD_W]);
	assign in_box.hi_y = field_coord(s_axis_tdata[OFS_MAX_Y +: FIELD_W]);
	assign in_box.hi_z = field_coord(s_axis_tdata[OFS_MAX_Z +: FIELD_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			far_en_q <= 1'b0;
		end else if (cfg_we) begin
			far_en_q <= cfg_wdata;
		end
	end

	// Loads take effect at acceptance, so a box right behind a load sees it.
	always_ff @(posedge clk) begin
		for (int p = 0; p < NUM_PLANES; p++) begin
			if (accept && is_load && (pidx == PIDX_W'(p))) begin
				plane_q[p] <= in_plane;
				sel_q[p]   <= {~in_plane.c[COORD_W-1], ~in_plane.b[COORD_W-1],
					~in_plane.a[COORD_W-1]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= s_axis_tvalid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			is_test_s1 <= !is_load;
			box_s1     <= in_box;
			is_test_s2 <= is_test_s1;
			is_test_q  <= is_test_s2;
			culled_q   <= is_test_s2 && |(outside & plane_en);
		end
	end

	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
		afc_plane_eval u_eval (
			.clk     (clk),
			.en      (adv),
			.plane   (plane_q[p]),
			.sel     (sel_q[p]),
			.box     (box_s1),
			.outside (outside[p])
		);
		assign plane_en[p] = (p == FAR_PLANE) ? far_en_q : 1'b1;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, culled_q};
	assign m_axis_tuser  = is_test_q;

	a_culled_only_tests: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && culled_q |-> is_test_q)
		else $error("load acknowledged as culled");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |-> !s_axis_tready)
		else $error("input accepted while output stalled");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1 && (is_test_s1 == !$past(is_load)))
		else $error("accepted word missing from first stage");

	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 |=> valid_s2 && (is_test_s2 == $past(is_test_s1)))
		else $error("first stage word lost");

endmodule

### dv/tb_aabb_frustum_cull.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_aabb_frustum_cull
// Self-checking bench for the frustum cull block. Plane loads and box tests are
// queued by the stimulus process. A clocked driver plays them out under random
// source gaps, and a clocked watcher predicts every verdict with exact wide
// arithmetic and checks each output word in order against that prediction.
// -----------------------------------------------------------------------------
module tb_aabb_frustum_cull;
	import afc_pkg::*;

	localparam int     ACC_W      = 2 * COORD_W + 4;
	localparam int     CYCLE_CAP  = 400000;
	localparam int     PHASE_LEN  = 600;
	localparam coord_t C_MIN      = 32'sh8000_0000;
	localparam coord_t C_MAX      = 32'sh7fff_ffff;
	localparam coord_t C_ONE      = 32'sh0001_0000;

	typedef struct packed {
		mode_t              mode;
		logic [PIDX_W-1:0]  pidx;
		plane_t             plane;
		box_t               box;
	} cull_item_t;

	typedef struct packed {
		logic culled;
		logic is_test;
	} verdict_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic                   cfg_wdata = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [0:0]             s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [0:0]             m_axis_tuser;

	cull_item_t        pending_items[$];
	verdict_t          expected_verdicts[$];
	cull_item_t        item_on_bus;
	logic              word_taken = 1'b0;
	int unsigned       send_gap_pct = 0;
	int unsigned       recv_gap_pct = 0;
	int unsigned       cycle_count = 0;
	int unsigned       error_count = 0;
	int unsigned       queued_count = 0;

	plane_t            plane_copy [NUM_PLANES];
	logic [AXES-1:0]   corner_copy [NUM_PLANES];
	logic              far_enable_copy = 1'b0;

	aabb_frustum_cull u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #6 clk = ~clk;

	function automatic logic [IN_TDATA_W-1:0] pack_item(cull_item_t it);
		logic [IN_TDATA_W-1:0] d;
		d = '0;
		d[PIDX_W-1:0]             = it.pidx;
		d[OFS_A +: FIELD_W]       = it.plane.a;
		d[OFS_B +: FIELD_W]       = it.plane.b;
		d[OFS_C +: FIELD_W]       = it.plane.c;
		d[OFS_D +: FIELD_W]       = it.plane.d;
		d[OFS_MIN_X +: FIELD_W]   = it.box.lo_x;
		d[OFS_MIN_Y +: FIELD_W]   = it.box.lo_y;
		d[OFS_MIN_Z +: FIELD_W]   = it.box.lo_z;
		d[OFS_MAX_X +: FIELD_W]   = it.box.hi_x;
		d[OFS_MAX_Y +: FIELD_W]   = it.box.hi_y;
		d[OFS_MAX_Z +: FIELD_W]   = it.box.hi_z;
		return d;
	endfunction

	// Updates the plane copy on loads and returns the verdict for the word.
	function automatic verdict_t predict_verdict(cull_item_t it);
		verdict_t              v;
		plane_t                pl;
		logic [AXES-1:0]       sel;
		logic signed [ACC_W-1:0] ca, cb, cc, cd, px, py, pz, acc;
		v.culled  = 1'b0;
		v.is_test = (it.mode == MODE_TEST);
		if (it.mode == MODE_LOAD) begin
			if (it.pidx < NUM_PLANES) begin
				plane_copy[it.pidx]  = it.plane;
				corner_copy[it.pidx] = {~it.plane.c[COORD_W-1], ~it.plane.b[COORD_W-1],
					~it.plane.a[COORD_W-1]};
			end
			return v;
		end
		for (int p = 0; p < NUM_PLANES; p++) begin
			if (p == FAR_PLANE && !far_enable_copy)
				continue;
			pl  = plane_copy[p];
			sel = corner_copy[p];
			ca  = pl.a;
			cb  = pl.b;
			cc  = pl.c;
			cd  = pl.d;
			px  = sel[0] ? it.box.hi_x : it.box.lo_x;
			py  = sel[1] ? it.box.hi_y : it.box.lo_y;
			pz  = sel[2] ? it.box.hi_z : it.box.lo_z;
			acc = ca * px + cb * py + cc * pz + (cd <<< 16);
			if (acc[ACC_W-1])
				v.culled = 1'b1;
		end
		return v;
	endfunction

	function automatic coord_t rand_coord(int unsigned span);
		if (span == 0)
			return coord_t'($urandom());
		return coord_t'($urandom_range(0, 2 * span)) - coord_t'(span);
	endfunction

	function automatic coord_t rand_extreme();
		case ($urandom_range(3))
			0: return C_MIN;
			1: return -1;
			2: return 0;
			default: return C_MAX;
		endcase
	endfunction

	function automatic coord_t rand_coef();
		case ($urandom_range(3))
			0: return rand_coord(0);
			1: return rand_extreme();
			default: return rand_coord(1 << 17);
		endcase
	endfunction

	function automatic void rand_span(output coord_t lo, output coord_t hi);
		coord_t      u, v;
		int unsigned kind;
		kind = $urandom_range(9);
		if (kind < 6) begin
			u = rand_coord(1 << 20);
			v = rand_coord(1 << 20);
		end else if (kind < 9) begin
			u = rand_coord(0);
			v = rand_coord(0);
		end else begin
			u = rand_extreme();
			v = rand_extreme();
		end
		if (u > v && $urandom_range(99) < 85) begin
			lo = v;
			hi = u;
		end else begin
			lo = u;
			hi = v;
		end
	endfunction

	function automatic cull_item_t rand_item();
		cull_item_t it;
		it.mode       = mode_t'($urandom_range(1));
		it.pidx       = PIDX_W'($urandom_range(7));
		it.plane.a    = rand_coord(0);
		it.plane.b    = rand_coord(0);
		it.plane.c    = rand_coord(0);
		it.plane.d    = rand_coord(0);
		it.box.lo_x   = rand_coord(0);
		it.box.lo_y   = rand_coord(0);
		it.box.lo_z   = rand_coord(0);
		it.box.hi_x   = rand_coord(0);
		it.box.hi_y   = rand_coord(0);
		it.box.hi_z   = rand_coord(0);
		return it;
	endfunction

	task automatic push_load(int unsigned idx, coord_t a, coord_t b, coord_t c, coord_t d);
		cull_item_t it;
		it         = rand_item();
		it.mode    = MODE_LOAD;
		it.pidx    = PIDX_W'(idx);
		it.plane   = '{a: a, b: b, c: c, d: d};
		pending_items = {pending_items, it};
		queued_count++;
	endtask

	task automatic push_test(coord_t lx, coord_t ly, coord_t lz, coord_t hx, coord_t hy,
		coord_t hz);
		cull_item_t it;
		it      = rand_item();
		it.mode = MODE_TEST;
		it.box  = '{lo_x: lx, lo_y: ly, lo_z: lz, hi_x: hx, hi_y: hy, hi_z: hz};
		pending_items = {pending_items, it};
		queued_count++;
	endtask

	task automatic push_rand_plane(int unsigned idx);
		coord_t d;
		if ($urandom_range(99) < 85)
			d = coord_t'($urandom_range(0, 32'h7fff_ffff));
		else
			d = rand_coord(0);
		push_load(idx, rand_coef(), rand_coef(), rand_coef(), d);
	endtask

	task automatic push_rand_box();
		coord_t lx, ly, lz, hx, hy, hz;
		rand_span(lx, hx);
		rand_span(ly, hy);
		rand_span(lz, hz);
		push_test(lx, ly, lz, hx, hy, hz);
	endtask

	// One frame: a full plane set, then a stream of boxes with rare reloads.
	task automatic push_frame(int unsigned boxes);
		for (int p = 0; p < NUM_PLANES; p++) begin
			push_rand_plane(p);
			if ($urandom_range(99) < 10)
				push_rand_plane($urandom_range(NUM_PLANES, 7));
		end
		for (int n = 0; n < boxes; n++) begin
			if ($urandom_range(99) < 5)
				push_rand_plane($urandom_range(7));
			push_rand_box();
		end
	endtask

	task automatic run_phase(int unsigned words);
		queued_count = 0;
		while (queued_count < words)
			push_frame($urandom_range(10, 60));
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || s_axis_tvalid || expected_verdicts.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_far_enable(logic value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	always @(negedge clk) begin : drive
		cull_item_t nxt;
		if (arst_n && (!s_axis_tvalid || word_taken)) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				nxt           = pending_items.pop_front();
				item_on_bus   = nxt;
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= pack_item(nxt);
				s_axis_tuser  <= nxt.mode;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		m_axis_tready <= arst_n && ($urandom_range(99) >= recv_gap_pct);
	end

	always @(posedge clk) begin : watch
		verdict_t want;
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("aabb_frustum_cull verification failed");
			$finish;
		end else if (arst_n) begin
			if (cfg_we)
				far_enable_copy = cfg_wdata;
			word_taken = s_axis_tvalid && s_axis_tready;
			if (word_taken) begin
				want = predict_verdict(item_on_bus);
				expected_verdicts = {expected_verdicts, want};
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_verdicts.size() == 0) begin
					$error("result word with no expectation waiting");
					error_count++;
				end else begin
					want = expected_verdicts.pop_front();
					if (m_axis_tdata[0] !== want.culled) begin
						$error("culled: expected %0d, got %0d", want.culled, m_axis_tdata[0]);
						error_count++;
					end
					if (m_axis_tuser[0] !== want.is_test) begin
						$error("is_test: expected %0d, got %0d", want.is_test,
							m_axis_tuser[0]);
						error_count++;
					end
				end
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_gap_pct = 33;
		recv_gap_pct = 76;
		write_far_enable(1'b0);

		// Extreme planes first, so that every plane is loaded before any test.
		push_load(0, C_MIN, C_MIN, C_MIN, C_MIN);
		push_load(1, C_MAX, C_MAX, C_MAX, C_MAX);
		push_load(2, 0, 0, 0, 0);
		push_load(3, C_ONE, -C_ONE, 0, 0);
		push_load(4, -1, 1, -1, C_MAX);
		push_load(5, 0, 0, 0, 1);
		push_load(6, C_MIN, C_MAX, -1, C_MIN);
		push_load(7, C_MAX, C_MIN, 1, C_MIN);
		push_test(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
		push_test(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
		push_test(0, 0, 0, 0, 0, 0);
		push_test(-1, -1, -1, 1, 1, 1);
		wait_idle();

		write_far_enable(1'b1);
		push_test(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
		push_test(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
		push_test(0, 0, 0, 0, 0, 0);
		push_load(1, 0, 0, 0, -1);
		push_load(0, C_MAX, 0, 0, C_MAX);
		push_test(-1, -1, -1, 1, 1, 1);
		push_test(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX);
		wait_idle();

		run_phase(PHASE_LEN);
		wait_idle();

		send_gap_pct = 76;
		recv_gap_pct = 33;
		write_far_enable(1'b0);
		run_phase(PHASE_LEN);
		wait_idle();

		send_gap_pct = 0;
		recv_gap_pct = 0;
		write_far_enable(1'($urandom_range(1)));
		run_phase(PHASE_LEN);
		wait_idle();

		repeat (8) @(posedge clk);
		if (error_count == 0 && expected_verdicts.size() == 0) begin
			$display("aabb_frustum_cull verification clean");
		end else begin
			$display("aabb_frustum_cull verification failed");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/afc_pkg.sv
hw/rtl/afc_plane_eval.sv
hw/rtl/aabb_frustum_cull.sv
dv/tb_aabb_frustum_cull.sv
